@@ hw/rtl/mrc_pkg.sv @@
`default_nettype none
package mrc_pkg;

  localparam int MOTORS_DEF    = 4;
  localparam int MAX_REPLY_DEF = 13;
  localparam int EVQ_DEPTH     = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  localparam logic [15:0] TIMEOUT_RST = 16'd10;
  localparam logic [7:0]  LIMIT_RST   = 8'd5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CRC     = 3'd1,
    ST_ID      = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_t;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_LIMIT   = 1'b1
  } reg_idx_t;

  // One finished transaction or one rejected start, handed to the back end
  typedef struct packed {
    logic        report_only;
    status_t     status;
    logic [3:0]  motor;
    logic [3:0]  seen;
  } ev_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mrc_front.sv @@
`default_nettype none
module mrc_front
  import mrc_pkg::*;
#(
  parameter int MAX_REPLY = MAX_REPLY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  motor_index,
  input  wire logic [7:0]  station_id,
  input  wire logic [7:0]  frame_length,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] timeout_ticks,
  output logic             ev_valid,
  output ev_t              ev
);

  localparam int CW = $clog2(MAX_REPLY + 1);

  logic          busy_r, busy_nxt;
  logic [3:0]    motor_r, motor_nxt;
  logic [7:0]    station_r, station_nxt;
  logic [CW-1:0] wlen_r, wlen_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          id_ok_r, id_ok_nxt;
  logic          crc_lo_ok_r, crc_lo_ok_nxt;
  logic [16:0]   elapsed_r, elapsed_nxt;

  logic [CW:0]   idx2;
  logic [CW:0]   wlen_x;
  logic [CW-1:0] bcnt_inc;
  logic          id_now;
  logic [16:0]   limit;
  logic [CW+3:0] seen_cur, seen_inc;

  always_comb begin
    idx2     = {1'b0, bcnt_r} + (CW+1)'(2);
    wlen_x   = {1'b0, wlen_r};
    bcnt_inc = bcnt_r + CW'(1);
    id_now   = (bcnt_r == '0) ? (rx_byte == station_r) : id_ok_r;
    limit    = (bcnt_r != '0) ? {timeout_ticks, 1'b0} : {1'b0, timeout_ticks};
    seen_cur = {4'b0000, bcnt_r};
    seen_inc = {4'b0000, bcnt_inc};
  end

  always_comb begin
    busy_nxt      = busy_r;
    motor_nxt     = motor_r;
    station_nxt   = station_r;
    wlen_nxt      = wlen_r;
    bcnt_nxt      = bcnt_r;
    crc_nxt       = crc_r;
    id_ok_nxt     = id_ok_r;
    crc_lo_ok_nxt = crc_lo_ok_r;
    elapsed_nxt   = elapsed_r;
    ev_valid      = 1'b0;
    ev            = '{report_only: 1'b0, status: ST_OK, motor: motor_r, seen: 4'd0};

    if (accept) begin
      case (cmd_t'(command))
        CMD_START: begin
          busy_nxt = 1'b0;
          if ({1'b0, frame_length} > 9'(MAX_REPLY)) begin
            ev_valid = 1'b1;
            ev = '{report_only: 1'b1, status: ST_BAD_LEN, motor: motor_index, seen: 4'd0};
          end else begin
            motor_nxt     = motor_index;
            station_nxt   = station_id;
            wlen_nxt      = CW'(frame_length);
            bcnt_nxt      = '0;
            crc_nxt       = CRC_INIT;
            id_ok_nxt     = 1'b0;
            crc_lo_ok_nxt = 1'b0;
            elapsed_nxt   = '0;
            if (frame_length == 8'd0) begin
              ev_valid = 1'b1;
              ev = '{report_only: 1'b0, status: ST_BAD_LEN, motor: motor_index, seen: 4'd0};
            end else begin
              busy_nxt = 1'b1;
            end
          end
        end
        CMD_BYTE: begin
          if (busy_r) begin
            if (bcnt_r == '0) id_ok_nxt = id_now;
            if (wlen_r >= CW'(2)) begin
              if (idx2 < wlen_x) crc_nxt = crc_byte(crc_r, rx_byte);
              else if (idx2 == wlen_x) crc_lo_ok_nxt = (rx_byte == crc_r[7:0]);
            end
            bcnt_nxt = bcnt_inc;
            if (bcnt_inc >= wlen_r) begin
              busy_nxt    = 1'b0;
              ev_valid    = 1'b1;
              ev.seen     = seen_inc[3:0];
              if (!id_now)                ev.status = ST_ID;
              else if (wlen_r < CW'(2))   ev.status = ST_BAD_LEN;
              else if (crc_lo_ok_r && rx_byte == crc_r[15:8]) ev.status = ST_OK;
              else                        ev.status = ST_CRC;
            end
          end
        end
        CMD_TICK: begin
          if (busy_r) begin
            if (elapsed_r < ELAPSED_MAX) elapsed_nxt = elapsed_r + 17'd1;
            if (elapsed_nxt > limit) begin
              busy_nxt  = 1'b0;
              ev_valid  = 1'b1;
              ev.status = ST_TIMEOUT;
              ev.seen   = seen_cur[3:0];
            end
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      motor_r     <= '0;
      station_r   <= '0;
      wlen_r      <= '0;
      bcnt_r      <= '0;
      crc_r       <= CRC_INIT;
      id_ok_r     <= 1'b0;
      crc_lo_ok_r <= 1'b0;
      elapsed_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      motor_r     <= motor_nxt;
      station_r   <= station_nxt;
      wlen_r      <= wlen_nxt;
      bcnt_r      <= bcnt_nxt;
      crc_r       <= crc_nxt;
      id_ok_r     <= id_ok_nxt;
      crc_lo_ok_r <= crc_lo_ok_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mrc_evq.sv @@
`default_nettype none
module mrc_evq
  import mrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  ev_t       wr_data,
  output logic      q_full,
  output logic      rd_valid,
  input  wire logic rd_en,
  output ev_t       rd_data
);

  localparam int PW = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
  localparam int NW = $clog2(EVQ_DEPTH + 1);

  ev_t           mem_r [EVQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full   = (cnt_r == NW'(EVQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    do_wr      = wr_en && !q_full;
    do_rd      = rd_en && rd_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + NW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mrc_back.sv @@
`default_nettype none
module mrc_back
  import mrc_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       ev_valid,
  input  ev_t             ev,
  output logic            ev_take,
  input  wire logic [7:0] error_limit,
  output logic            out_valid,
  input  wire logic       out_take,
  output logic [2:0]      status,
  output logic [3:0]      motor_of_result,
  output logic [7:0]      error_count,
  output logic            line_off,
  output logic [3:0]      bytes_seen
);

  localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [7:0]    fail_r [MOTORS];
  logic          valid_r, valid_nxt;
  logic [2:0]    status_r;
  logic [3:0]    motor_r;
  logic [7:0]    count_r;
  logic          off_r;
  logic [3:0]    seen_r;

  logic          known;
  logic [MW-1:0] idx;
  logic [7:0]    cur, upd, cnt_res;
  logic          off_res;

  assign ev_take = ev_valid && (!valid_r || out_take);

  always_comb begin
    known   = ({1'b0, ev.motor} < 5'(MOTORS));
    idx     = ev.motor[MW-1:0];
    cur     = known ? fail_r[idx] : 8'd0;
    upd     = cur;
    off_res = 1'b0;
    if (ev.status == ST_OK) begin
      if (cur != 8'd0) upd = cur - 8'd1;
    end else begin
      if (cur != COUNT_MAX) upd = cur + 8'd1;
      if (upd > error_limit) begin
        upd     = 8'd0;
        off_res = 1'b1;
      end
    end
    // rejected starts and unknown motors only report the current count
    if (ev.report_only || !known) begin
      cnt_res = cur;
      off_res = 1'b0;
    end else begin
      cnt_res = upd;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ev_take)       valid_nxt = 1'b1;
    else if (out_take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int m = 0; m < MOTORS; m++) fail_r[m] <= 8'd0;
    end else begin
      valid_r <= valid_nxt;
      if (ev_take && known && !ev.report_only) fail_r[idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      status_r <= ev.status;
      motor_r  <= ev.motor;
      count_r  <= cnt_res;
      off_r    <= off_res;
      seen_r   <= ev.seen;
    end
  end

  assign out_valid       = valid_r;
  assign status          = status_r;
  assign motor_of_result = motor_r;
  assign error_count     = count_r;
  assign line_off        = off_r;
  assign bytes_seen      = seen_r;

endmodule
`default_nettype wire

@@ hw/rtl/modbus_response_checker_top.sv @@
`default_nettype none
// Modbus RTU reply checker.
// Input side is a queue: drive command and its fields, raise push; the beat is
// taken on a clock edge with push high and full low. Start beats open a reply
// for a motor, byte beats feed reply bytes, tick beats count milliseconds.
// Result side is a queue too: while empty is low the oldest result sits on the
// out_ ports; pop with empty low takes it. Only beats that end a transaction
// (or reject a start) produce a result.
// A result passes through the event queue and then the output register before it
// shows on the out_ ports. Throughput: one beat per cycle on both sides while full
// is low and pop is high; the CRC update of one byte is an unrolled combinational step.
// The front end pushes finished transactions and rejected starts into a two-entry
// event queue; the back end updates the per-motor failure count and loads the
// output register. When the receiver stalls, results wait in the output register
// and the event queue; full rises once both are occupied, and nothing is dropped.
// Reset (rst_n low, synchronous) clears all failure counts, ends any open
// transaction, empties both queues and loads timeout 10 ticks and limit 5.
// Registers via cfg_we/cfg_index/cfg_wdata: 0 timeout ticks, 1 error limit.
module modbus_response_checker_top
  import mrc_pkg::*;
#(
  parameter int MOTORS    = MOTORS_DEF,
  parameter int MAX_REPLY = MAX_REPLY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_motor_index,
  input  wire logic [7:0]  in_station_id,
  input  wire logic [7:0]  in_frame_length,
  input  wire logic [7:0]  in_rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_status,
  output logic [3:0]       out_motor_of_result,
  output logic [7:0]       out_error_count,
  output logic             out_line_off,
  output logic [3:0]       out_bytes_seen
);

  logic [15:0] timeout_r;
  logic [7:0]  limit_r;
  logic        accept;
  logic        fe_valid;
  ev_t         fe_ev;
  logic        q_valid;
  ev_t         q_ev;
  logic        q_take;
  logic        o_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      limit_r   <= LIMIT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        REG_LIMIT:   limit_r   <= cfg_wdata[7:0];
        default:     timeout_r <= timeout_r;
      endcase
    end
  end

  assign accept = push && !full;
  assign empty  = !o_valid;

  mrc_front #(.MAX_REPLY(MAX_REPLY)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .command       (in_command),
    .motor_index   (in_motor_index),
    .station_id    (in_station_id),
    .frame_length  (in_frame_length),
    .rx_byte       (in_rx_byte),
    .timeout_ticks (timeout_r),
    .ev_valid      (fe_valid),
    .ev            (fe_ev)
  );

  mrc_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fe_valid),
    .wr_data  (fe_ev),
    .q_full   (full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_data  (q_ev)
  );

  mrc_back #(.MOTORS(MOTORS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .ev_valid        (q_valid),
    .ev              (q_ev),
    .ev_take         (q_take),
    .error_limit     (limit_r),
    .out_valid       (o_valid),
    .out_take        (pop),
    .status          (out_status),
    .motor_of_result (out_motor_of_result),
    .error_count     (out_error_count),
    .line_off        (out_line_off),
    .bytes_seen      (out_bytes_seen)
  );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

import mrc_pkg::*;

typedef struct {
  status_t     status;
  logic [3:0]  motor;
  logic [7:0]  count;
  logic        line_off;
  logic [3:0]  seen;
} reply_outcome_t;

// Bit-serial CRC-16/MODBUS, LSB first
function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
  logic [15:0] acc;
  acc = crc;
  for (int i = 0; i < 8; i++) begin
    if (acc[0] ^ data[i]) acc = (acc >> 1) ^ CRC_POLY;
    else acc = acc >> 1;
  end
  return acc;
endfunction

class reply_check_scoreboard;
  logic [15:0]    timeout_ticks;
  logic [7:0]     error_limit;
  bit             reply_open;
  logic [3:0]     cur_motor;
  logic [7:0]     want_station;
  logic [3:0]     want_length;
  logic [3:0]     byte_count;
  logic [15:0]    crc;
  bit             id_ok;
  bit             crc_low_ok;
  logic [16:0]    elapsed;
  logic [7:0]     fail_counts [MOTORS_DEF];
  reply_outcome_t expected_outcomes [$];
  int             mismatches;

  function new();
    timeout_ticks = TIMEOUT_RST;
    error_limit   = LIMIT_RST;
    reply_open    = 0;
    cur_motor     = '0;
    want_station  = '0;
    want_length   = '0;
    byte_count    = '0;
    crc           = CRC_INIT;
    id_ok         = 0;
    crc_low_ok    = 0;
    elapsed       = '0;
    mismatches    = 0;
    foreach (fail_counts[m]) fail_counts[m] = '0;
  endfunction

  function void set_register(reg_idx_t idx, logic [15:0] value);
    if (idx == REG_TIMEOUT) timeout_ticks = value;
    else error_limit = value[7:0];
  endfunction

  // Update the motor's failure count and queue the outcome of an ended reply
  function void close_reply(status_t status, logic [3:0] motor, logic [3:0] seen);
    reply_outcome_t o;
    int count;
    count = 0;
    reply_open = 0;
    o.line_off = 1'b0;
    if (motor < MOTORS_DEF) begin
      count = fail_counts[motor];
      if (status == ST_OK) begin
        if (count > 0) count--;
      end else begin
        if (count < 255) count++;
        if (count > error_limit) begin
          count = 0;
          o.line_off = 1'b1;
        end
      end
      fail_counts[motor] = count[7:0];
    end
    o.status = status;
    o.motor  = motor;
    o.count  = count[7:0];
    o.seen   = seen;
    expected_outcomes.push_back(o);
  endfunction

  // Returns 0 for a beat that the block ignores
  function bit note_beat(logic [1:0] cmd, logic [3:0] motor, logic [7:0] station,
                         logic [7:0] length, logic [7:0] data);
    reply_outcome_t o;
    status_t verdict;
    int limit;
    case (cmd)
      CMD_START: begin
        reply_open = 0;
        if (length > MAX_REPLY_DEF) begin
          o.status   = ST_BAD_LEN;
          o.motor    = motor;
          o.count    = (motor < MOTORS_DEF) ? fail_counts[motor] : 8'd0;
          o.line_off = 1'b0;
          o.seen     = 4'd0;
          expected_outcomes.push_back(o);
          return 1;
        end
        cur_motor    = motor;
        want_station = station;
        want_length  = length[3:0];
        byte_count   = '0;
        crc          = CRC_INIT;
        id_ok        = 0;
        crc_low_ok   = 0;
        elapsed      = '0;
        if (length == 0) close_reply(ST_BAD_LEN, motor, 4'd0);
        else reply_open = 1;
        return 1;
      end
      CMD_BYTE: begin
        if (!reply_open) return 0;
        if (byte_count == 0) id_ok = (data == want_station);
        if (want_length >= 2) begin
          if (byte_count + 2 < want_length) crc = crc16_step(crc, data);
          else if (byte_count + 2 == want_length) crc_low_ok = (data == crc[7:0]);
        end
        byte_count++;
        if (byte_count >= want_length) begin
          if (!id_ok) verdict = ST_ID;
          else if (want_length < 2) verdict = ST_BAD_LEN;
          else if (crc_low_ok && data == crc[15:8]) verdict = ST_OK;
          else verdict = ST_CRC;
          close_reply(verdict, cur_motor, byte_count);
        end
        return 1;
      end
      CMD_TICK: begin
        if (!reply_open) return 0;
        limit = (byte_count > 0) ? 2 * int'(timeout_ticks) : int'(timeout_ticks);
        if (elapsed != ELAPSED_MAX) elapsed++;
        if (elapsed > limit) close_reply(ST_TIMEOUT, cur_motor, byte_count);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task check_outcome(logic [2:0] status, logic [3:0] motor, logic [7:0] count,
                     logic line_off, logic [3:0] seen);
    reply_outcome_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: status %0d motor %0d",
                                status, motor));
      return;
    end
    want = expected_outcomes.pop_front();
    if (status !== want.status || motor !== want.motor || count !== want.count ||
        line_off !== want.line_off || seen !== want.seen)
      report_mismatch($sformatf(
        "status/motor/count/off/seen got %0d %0d %0d %0b %0d want %0d %0d %0d %0b %0d",
        status, motor, count, line_off, seen,
        want.status, want.motor, want.count, want.line_off, want.seen));
  endtask
endclass

module testbench;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         PHASE_BEATS    = 50;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic        cfg_index       = 1'b0;
  logic [15:0] cfg_wdata       = '0;
  logic        push            = 1'b0;
  logic [1:0]  in_command      = '0;
  logic [3:0]  in_motor_index  = '0;
  logic [7:0]  in_station_id   = '0;
  logic [7:0]  in_frame_length = '0;
  logic [7:0]  in_rx_byte      = '0;
  logic        pop             = 1'b0;
  logic        full;
  logic        empty;
  logic [2:0]  out_status;
  logic [3:0]  out_motor_of_result;
  logic [7:0]  out_error_count;
  logic        out_line_off;
  logic [3:0]  out_bytes_seen;

  // Mid-cycle copies of the outputs, stable across the next rising edge
  logic        full_s  = 1'b1;
  logic        empty_s = 1'b1;
  logic [2:0]  status_s;
  logic [3:0]  motor_s;
  logic [7:0]  count_s;
  logic        off_s;
  logic [3:0]  seen_s;

  reply_check_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_in      = 0;
  int beats_out     = 0;
  int used_beats    = 0;
  int hold_left     = 0;
  bit hold_request  = 0;

  always #5 clk = ~clk;

  modbus_response_checker_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .full                (full),
    .in_command          (in_command),
    .in_motor_index      (in_motor_index),
    .in_station_id       (in_station_id),
    .in_frame_length     (in_frame_length),
    .in_rx_byte          (in_rx_byte),
    .empty               (empty),
    .pop                 (pop),
    .out_status          (out_status),
    .out_motor_of_result (out_motor_of_result),
    .out_error_count     (out_error_count),
    .out_line_off        (out_line_off),
    .out_bytes_seen      (out_bytes_seen)
  );

  always @(negedge clk) begin
    full_s   = full;
    empty_s  = empty;
    status_s = out_status;
    motor_s  = out_motor_of_result;
    count_s  = out_error_count;
    off_s    = out_line_off;
    seen_s   = out_bytes_seen;
  end

  // Result side: take beats, idle at random, hold off on request
  always @(posedge clk) begin
    if (rst_n && pop && !empty_s) begin
      sb.check_outcome(status_s, motor_s, count_s, off_s, seen_s);
      beats_out++;
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    int last_in;
    int last_out;
    quiet = 0;
    last_in = 0;
    last_out = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (beats_in != last_in || beats_out != last_out) quiet = 0;
      else quiet++;
      last_in = beats_in;
      last_out = beats_out;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_beat(logic [1:0] cmd, logic [3:0] motor, logic [7:0] station,
                           logic [7:0] length, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_command      <= cmd;
    in_motor_index  <= motor;
    in_station_id   <= station;
    in_frame_length <= length;
    in_rx_byte      <= data;
    do @(posedge clk); while (full_s);
    beats_in++;
    if (sb.note_beat(cmd, motor, station, length, data)) used_beats++;
  endtask

  task automatic send_start(logic [3:0] motor, logic [7:0] station, logic [7:0] length);
    send_beat(CMD_START, motor, station, length, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] data);
    send_beat(CMD_BYTE, 4'($urandom), 8'($urandom), 8'($urandom), data);
  endtask

  task automatic send_tick();
    send_beat(CMD_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic write_register(reg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_register(idx, value);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Let every pending result come out, then the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] timeout, logic [7:0] limit);
    wait_drained();
    write_register(REG_TIMEOUT, timeout);
    write_register(REG_LIMIT, {8'd0, limit});
  endtask

  // Start a reply and feed its first keep bytes, with the requested damage
  task automatic send_frame(logic [3:0] motor, logic [7:0] station, int length, int keep,
                            bit bad_id, bit bad_lo, bit bad_hi, int tick_pct);
    logic [7:0]  frame [$];
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    send_start(motor, station, 8'(length));
    if (length < 1 || length > MAX_REPLY_DEF) return;
    for (int i = 0; i < length; i++) begin
      if (length >= 2 && i == length - 1) b = crc[15:8];
      else if (i == length - 2) b = crc[7:0];
      else if (i == 0) b = station;
      else b = 8'($urandom);
      if (i < length - 2) crc = crc16_step(crc, b);
      frame.push_back(b);
    end
    if (bad_id) frame[0] = frame[0] ^ 8'($urandom_range(255, 1));
    if (bad_lo && length >= 2) frame[length-2] = frame[length-2] ^ 8'($urandom_range(255, 1));
    if (bad_hi && length >= 2) frame[length-1] = frame[length-1] ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < keep && i < length; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      send_byte(frame[i]);
    end
  endtask

  task automatic random_reply();
    logic [3:0] motor;
    logic [7:0] station;
    int length;
    int keep;
    int pick;
    bit bad_id;
    bit bad_lo;
    bit bad_hi;
    bit stalled;
    motor = ($urandom_range(99) < 80) ? 4'($urandom_range(MOTORS_DEF - 1)) : 4'($urandom);
    station = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 84) length = $urandom_range(MAX_REPLY_DEF, 2);
    else if (pick < 90) length = $urandom_range(1);
    else length = $urandom_range(255, MAX_REPLY_DEF + 1);
    bad_id = 0;
    bad_lo = 0;
    bad_hi = 0;
    stalled = 0;
    keep = length;
    pick = $urandom_range(99);
    if (pick < 60) begin
    end else if (pick < 70) begin
      bad_id = 1;
    end else if (pick < 78) begin
      bad_lo = 1;
    end else if (pick < 86) begin
      bad_hi = 1;
    end else if (pick < 90) begin
      bad_id = 1;
      bad_hi = 1;
    end else begin
      // cut the reply short; either let it time out or abandon it
      keep = (length > 0) ? $urandom_range(length - 1) : 0;
      stalled = (pick < 96);
    end
    send_frame(motor, station, length, keep, bad_id, bad_lo, bad_hi, 6);
    if (stalled && sb.timeout_ticks <= 16)
      while (sb.reply_open) send_tick();
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(2))
        0: send_byte(8'($urandom));
        1: send_tick();
        default: send_beat(CMD_UNUSED, 4'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
      endcase
    end
  endtask

  task automatic run_random(int beats);
    int first;
    first = used_beats;
    while (used_beats - first < beats) random_reply();
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_register(REG_TIMEOUT, 16'd2);
    send_start(4'd0, 8'h11, 8'd255);
    send_start(4'd15, 8'hFF, 8'd14);
    send_start(4'd1, 8'h00, 8'd0);
    send_frame(4'd2, 8'hA5, 1, 1, 0, 0, 0, 0);
    send_frame(4'd2, 8'hA5, 1, 1, 1, 0, 0, 0);
    send_frame(4'd0, 8'h11, 3, 3, 0, 0, 0, 0);
    send_frame(4'd0, 8'h11, 3, 3, 0, 1, 0, 0);
    send_frame(4'd0, 8'h11, 4, 4, 0, 0, 1, 0);
    send_frame(4'd0, 8'h11, 3, 3, 1, 0, 1, 0);
    // restart mid-reply: drop the open one silently
    send_frame(4'd3, 8'h7E, 6, 1, 0, 0, 0, 0);
    send_frame(4'd3, 8'hFF, 2, 2, 0, 0, 0, 0);
    send_byte(8'h00);
    send_tick();
    send_beat(CMD_UNUSED, 4'hF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(4'd9, 8'h20, 1, 1, 1, 0, 0, 0);
    send_start(4'd1, 8'h01, 8'd13);
    repeat (3) send_tick();

    apply_settings(16'd1, 8'd0);
    run_random(PHASE_BEATS);
    apply_settings(16'd3, 8'd254);
    run_random(PHASE_BEATS);

    send_idle_pct = 79;
    recv_idle_pct = 32;
    apply_settings(16'd2, 8'd1);
    run_random(PHASE_BEATS);
    // drive one motor's failure count into saturation
    apply_settings(16'd5, 8'd255);
    repeat (260) send_start(4'd3, 8'($urandom), 8'd0);
    run_random(PHASE_BEATS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    hold_request = 1;
    repeat (24) send_start(4'($urandom), 8'($urandom), 8'd0);

    // a byte seen doubles the timeout: runs to the doubled limit
    apply_settings(16'd40, 8'd254);
    send_frame(4'd1, 8'h42, 6, 1, 0, 0, 0, 0);
    while (sb.reply_open) send_tick();

    apply_settings(TIMEOUT_RST, LIMIT_RST);
    run_random(PHASE_BEATS);
    apply_settings(16'($urandom_range(12, 1)), 8'($urandom));
    run_random(PHASE_BEATS);

    wait_drained();
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_front.sv
hw/rtl/mrc_evq.sv
hw/rtl/mrc_back.sv
hw/rtl/modbus_response_checker_top.sv
verif/testbench.sv
